// ===== sv/rpm_pkg.sv =====
// Package for the RGBA pack and mip chain block; depends on nothing.
// Holds sizes, register indexes, alpha limits and the packed struct types.
`timescale 1ns / 1ps
package rpm_pkg;
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;
	localparam int DEF_MAX_LEVELS = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_COMPONENTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 2'd2;
	localparam logic [7:0] ALPHA_LIMIT  = 8'hF8;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [8:0] a;
		logic [8:0] r;
		logic [8:0] g;
		logic [8:0] b;
	} sum4_t;

	typedef struct packed {
		logic signed [31:0] sample_first;
		logic signed [31:0] sample_second;
		logic signed [31:0] sample_third;
		logic signed [31:0] sample_fourth;
	} pix_in_t;

	typedef struct packed {
		logic [3:0]  mip_level;
		logic [10:0] pos_x;
		logic [10:0] pos_y;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [7:0]  alpha;
		logic        alpha_seen;
		logic        run_last;
		logic        image_done;
	} pix_out_t;
endpackage

// ===== sv/rpm_if.sv =====
// Valid/ready stream interfaces for input pixels and mip results.
// Depends on rpm_pkg for the payload types.
`timescale 1ns / 1ps
interface rpm_in_if;
	import rpm_pkg::*;
	logic    valid;
	logic    ready;
	pix_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rpm_out_if;
	import rpm_pkg::*;
	logic     valid;
	logic     ready;
	pix_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rgba_pack_and_mip_chain.sv =====
// Top level: BGRA packer with a streaming 2x2 box-filter mip chain.
// Depends on rpm_pkg and the stream interfaces in rpm_if.sv.
`timescale 1ns / 1ps
// Pixels arrive in raster order on "pix"; each transfer produces one level-0
// result and, where the pixel completes a 2x2 block, a result for each
// coarser level it finishes, all on "res", the last one flagged run_last.
// One shared sum unit walks the levels under a small sequencer: a pixel
// is accepted in the idle state, each result it causes is issued in the
// emit state, and each cascaded level adds a line-buffer read state and
// an average state before the next emit.
// Each result waits in a single output register; the sequencer holds while
// it is not taken. The line buffer is one memory of MAX_WIDTH entries with
// one read and one write port.
// Configuration writes restart the image; issue them only while idle.
module rgba_pack_and_mip_chain #(
	parameter int MAX_WIDTH  = rpm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rpm_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_LEVELS = rpm_pkg::DEF_MAX_LEVELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpm_pkg::CFG_DATA_W-1:0] cfg_data,
	rpm_in_if.sink                        pix,
	rpm_out_if.source                     res
);
	import rpm_pkg::*;

	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int LVW = $clog2(MAX_LEVELS + 1);
	localparam int DW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int NPS = (MAX_LEVELS > 1) ? MAX_LEVELS - 1 : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EMIT = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_AVG  = 2'd3;

	logic [2:0]  cc_q;
	logic [11:0] width_cfg_q, height_cfg_q;
	logic [DW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [LVW-1:0] nlev;
	logic [1:0]  state_q;
	logic [10:0] in_col_q, in_row_q;
	logic [10:0] x_q, y_q;
	logic [LVW-1:0] lvl_q;
	logic [7:0]  b_q, g_q, r_q, a_q;
	logic        alpha_flag_q, last_pix_q;
	sum4_t       pair_sum_q [NPS];
	sum4_t       line_mem [MAX_WIDTH];
	sum4_t       top_s1, pair_q;
	logic [AW-1:0] idx_q;
	logic        out_valid_q;
	pix_out_t    out_q;

	// effective sizes, saturated, and the mip level count
	always_comb begin
		logic [12:0] m;
		int unsigned n;
		w_eff = (width_cfg_q == 12'd0) ? DW'(1) :
			((32'(width_cfg_q) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(width_cfg_q));
		h_eff = (height_cfg_q == 12'd0) ? HW'(1) :
			((32'(height_cfg_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_cfg_q));
		m = (32'(w_eff) < 32'(h_eff)) ? 13'(w_eff) : 13'(h_eff);
		n = 1;
		for (int i = 0; i < 14; i++)
			if (m > 13'd1 && n < MAX_LEVELS) begin
				m = m >> 1;
				n++;
			end
		nlev = LVW'(n);
	end

	// decode of the incoming pixel
	logic [2:0] cc_eff;
	logic [7:0] s0, s1, s2, s3;
	logic       has_alpha;
	logic signed [31:0] raw_a;
	always_comb begin
		cc_eff = (cc_q == 3'd0) ? 3'd1 : ((cc_q > 3'd4) ? 3'd4 : cc_q);
		s0 = pix.data.sample_first[7:0];
		s1 = pix.data.sample_second[7:0];
		s2 = pix.data.sample_third[7:0];
		s3 = pix.data.sample_fourth[7:0];
		has_alpha = (cc_eff == 3'd2) || (cc_eff == 3'd4);
		raw_a = (cc_eff == 3'd2) ? pix.data.sample_second : pix.data.sample_fourth;
	end

	logic [10:0] cur_col, cur_row;
	always_comb begin
		cur_col = (32'(in_col_q) >= 32'(w_eff)) ? 11'd0 : in_col_q;
		cur_row = (32'(in_row_q) >= 32'(h_eff)) ? 11'd0 : in_row_q;
	end

	// shared sum unit: current pixel plus one partner per channel
	// (the pair register is only used while a coarser level exists, so
	// lvl_q stays below NPS whenever the sum is taken)
	sum4_t partner, usum;
	always_comb begin
		partner = (state_q == ST_AVG) ? pair_q : pair_sum_q[lvl_q];
		usum.b = partner.b + 9'(b_q);
		usum.g = partner.g + 9'(g_q);
		usum.r = partner.r + 9'(r_q);
		usum.a = partner.a + 9'(a_q);
	end

	// cascade decision for the level held in lvl_q
	logic [11:0] cw, chh;
	logic        go_on, x_odd, y_odd, idx_ok;
	logic [AW:0] idx_full;
	always_comb begin
		cw  = 12'(32'(w_eff) >> (lvl_q + 1));
		chh = 12'(32'(h_eff) >> (lvl_q + 1));
		x_odd = x_q[0];
		y_odd = y_q[0];
		idx_full = (AW+1)'(MAX_WIDTH - (MAX_WIDTH >> lvl_q) + 32'(x_q >> 1));
		idx_ok = 32'(idx_full) < MAX_WIDTH;
		go_on = (32'(lvl_q) + 1 < 32'(nlev)) && (12'(x_q) < 12'(cw << 1))
			&& (12'(y_q) < 12'(chh << 1));
	end

	logic can_out;
	assign can_out = !out_valid_q || res.ready;
	assign pix.ready = (state_q == ST_IDLE) && !cfg_we;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	logic final_res;
	always_comb final_res = !go_on || !x_odd || !idx_ok || !y_odd;

	// park the pair sum of an even row in the line buffer
	logic lm_we;
	always_comb lm_we = !cfg_we && (state_q == ST_EMIT) && can_out && go_on && x_odd
		&& idx_ok && !y_odd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= 3'd4;
			width_cfg_q <= 12'd1024;
			height_cfg_q <= 12'd1024;
			state_q <= ST_IDLE;
			in_col_q <= '0;
			in_row_q <= '0;
			alpha_flag_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NPS; i++) pair_sum_q[i] <= '0;
		end else begin
			if (out_valid_q && res.ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				// restart the image on any listed register write
				if (cfg_index == REG_COMPONENTS) cc_q <= cfg_data[2:0];
				if (cfg_index == REG_WIDTH) width_cfg_q <= cfg_data;
				if (cfg_index == REG_HEIGHT) height_cfg_q <= cfg_data;
				if (cfg_index == REG_COMPONENTS || cfg_index == REG_WIDTH
					|| cfg_index == REG_HEIGHT) begin
					in_col_q <= '0;
					in_row_q <= '0;
					alpha_flag_q <= 1'b0;
					for (int i = 0; i < NPS; i++) pair_sum_q[i] <= '0;
				end
			end else begin
				case (state_q)
				ST_IDLE: begin
					if (pix.valid) begin
						if (has_alpha && (raw_a < $signed({24'd0, ALPHA_LIMIT})))
							alpha_flag_q <= 1'b1;
						b_q <= (cc_eff <= 3'd2) ? s0 : s2;
						g_q <= (cc_eff <= 3'd2) ? s0 : s1;
						r_q <= s0;
						a_q <= (cc_eff == 3'd2) ? s1 : ((cc_eff == 3'd4) ? s3 : ALPHA_OPAQUE);
						x_q <= cur_col;
						y_q <= cur_row;
						lvl_q <= '0;
						last_pix_q <= (32'(cur_col) == 32'(w_eff) - 1)
							&& (32'(cur_row) == 32'(h_eff) - 1);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (can_out) begin
						out_valid_q <= 1'b1;
						out_q.mip_level <= 4'(lvl_q);
						out_q.pos_x <= x_q;
						out_q.pos_y <= y_q;
						out_q.blue <= b_q;
						out_q.green <= g_q;
						out_q.red <= r_q;
						out_q.alpha <= a_q;
						out_q.alpha_seen <= alpha_flag_q;
						out_q.run_last <= final_res;
						out_q.image_done <= final_res && last_pix_q;
						if (go_on && !x_odd)
							pair_sum_q[lvl_q] <= '{a: 9'(a_q), r: 9'(r_q),
								g: 9'(g_q), b: 9'(b_q)};
						if (final_res) begin
							state_q <= ST_IDLE;
							if (last_pix_q) begin
								in_col_q <= '0;
								in_row_q <= '0;
								alpha_flag_q <= 1'b0;
								for (int i = 0; i < NPS; i++) pair_sum_q[i] <= '0;
							end else if (32'(cur_col) + 1 >= 32'(w_eff)) begin
								in_col_q <= '0;
								in_row_q <= (32'(cur_row) + 1 >= 32'(h_eff)) ? 11'd0
									: cur_row + 11'd1;
							end else begin
								in_col_q <= cur_col + 11'd1;
								in_row_q <= cur_row;
							end
						end else begin
							// advance to the read of the upper pair
							pair_q <= usum;
							idx_q <= idx_full[AW-1:0];
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_AVG;
				ST_AVG: begin
					pair_q <= top_s1;
					state_q <= ST_EMIT;
				end
				default: state_q <= ST_IDLE;
				endcase
			end
			// average step: top_s1 holds the upper pair, pair_q the lower; add and drop 2 bits
			if (!cfg_we && state_q == ST_AVG) begin
				b_q <= 8'((10'(top_s1.b) + 10'(pair_q.b)) >> 2);
				g_q <= 8'((10'(top_s1.g) + 10'(pair_q.g)) >> 2);
				r_q <= 8'((10'(top_s1.r) + 10'(pair_q.r)) >> 2);
				a_q <= 8'((10'(top_s1.a) + 10'(pair_q.a)) >> 2);
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				lvl_q <= lvl_q + LVW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lm_we) line_mem[idx_full[AW-1:0]] <= usum;
		if (state_q == ST_READ) top_s1 <= line_mem[idx_q];
	end
endmodule

// ===== sv/rpm_checker.sv =====
// Port-level checker for rgba_pack_and_mip_chain, bound to the top level.
// Depends on rpm_pkg and the stream interfaces.
`timescale 1ns / 1ps
module rpm_checker (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	input logic pix_ready,
	input logic res_valid,
	input logic res_ready,
	input rpm_pkg::pix_out_t res_data
);
	import rpm_pkg::*;

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.image_done |-> res_data.run_last)
		else $error("image_done without run_last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("accepted a pixel while busy");
	a_lvl0: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.mip_level != 4'd0 |-> res_data.pos_x < 11'd1024)
		else $error("coarse level column out of range");
endmodule

bind rgba_pack_and_mip_chain rpm_checker u_rpm_checker (
	.clk(clk), .arst_n(arst_n), .pix_valid(pix.valid), .pix_ready(pix.ready),
	.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for rgba_pack_and_mip_chain: packing, alpha flag and mip cascade.
// Depends on rpm_pkg, the stream interfaces in rpm_if.sv and the block's top level.
`timescale 1ns / 1ps
module testbench;
	import rpm_pkg::*;

	localparam int LIMIT_CYCLES = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rpm_in_if pix ();
	rpm_out_if res ();

	rgba_pack_and_mip_chain dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix(pix.sink), .res(res.source)
	);

	// predictor state, mirrors the block
	int unsigned comp_cnt, img_w, img_h;
	int unsigned col_cnt, row_cnt;
	bit alpha_low;
	sum4_t pair_acc [DEF_MAX_LEVELS];
	sum4_t line_sums [DEF_MAX_WIDTH];

	pix_in_t pending_pixels [$];
	pix_out_t expected_results [$];
	int unsigned errors;
	int unsigned idle_cycles;
	int unsigned out_stall;
	bit long_stall_req;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic sum4_t add4(sum4_t p, logic [7:0] b, logic [7:0] g, logic [7:0] r,
			logic [7:0] a);
		sum4_t s;
		s.b = p.b + 9'(b);
		s.g = p.g + 9'(g);
		s.r = p.r + 9'(r);
		s.a = p.a + 9'(a);
		return s;
	endfunction

	function automatic int unsigned mip_levels(int unsigned w, int unsigned h);
		int unsigned m;
		int unsigned n;
		m = (w < h) ? w : h;
		n = 1;
		while (m > 1 && n < DEF_MAX_LEVELS) begin
			m = m >> 1;
			n++;
		end
		return n;
	endfunction

	task automatic restart_image();
		col_cnt = 0;
		row_cnt = 0;
		alpha_low = 0;
		foreach (pair_acc[i]) pair_acc[i] = '0;
	endtask

	// Predict the results of one pixel and queue them.
	task automatic predict_mips(pix_in_t p);
		int unsigned w, h, nlev, cc, x, y, lvl, cw, ch, idx, first;
		logic [7:0] b, g, r, a;
		logic signed [31:0] araw;
		sum4_t pr, top, cur;
		pix_out_t o;
		bit last_px;
		w = (img_w == 0) ? 1 : (img_w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : img_w);
		h = (img_h == 0) ? 1 : (img_h > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : img_h);
		nlev = mip_levels(w, h);
		cc = (comp_cnt == 0) ? 1 : (comp_cnt > 4 ? 4 : comp_cnt);
		if (cc <= 2) begin
			b = p.sample_first[7:0];
			g = b;
			r = b;
		end else begin
			b = p.sample_third[7:0];
			g = p.sample_second[7:0];
			r = p.sample_first[7:0];
		end
		if (cc == 2 || cc == 4) begin
			araw = (cc == 2) ? p.sample_second : p.sample_fourth;
			if (araw < $signed({24'd0, ALPHA_LIMIT})) alpha_low = 1;
			a = araw[7:0];
		end else begin
			a = ALPHA_OPAQUE;
		end
		if (col_cnt >= w) col_cnt = 0;
		if (row_cnt >= h) row_cnt = 0;
		x = col_cnt;
		y = row_cnt;
		last_px = (x == w - 1) && (y == h - 1);
		lvl = 0;
		first = expected_results.size();
		forever begin
			o = '0;
			o.mip_level = 4'(lvl);
			o.pos_x = 11'(x);
			o.pos_y = 11'(y);
			o.blue = b;
			o.green = g;
			o.red = r;
			o.alpha = a;
			o.alpha_seen = alpha_low;
			expected_results.push_back(o);
			if (lvl + 1 >= nlev) break;
			cw = w >> (lvl + 1);
			ch = h >> (lvl + 1);
			if (x >= 2 * cw || y >= 2 * ch) break;
			cur = '0;
			cur = add4(cur, b, g, r, a);
			if (x[0] == 0) begin
				pair_acc[lvl] = cur;
				break;
			end
			pr = add4(pair_acc[lvl], b, g, r, a);
			idx = DEF_MAX_WIDTH - (DEF_MAX_WIDTH >> lvl) + (x >> 1);
			if (idx >= DEF_MAX_WIDTH) break;
			if (y[0] == 0) begin
				line_sums[idx] = pr;
				break;
			end
			top = line_sums[idx];
			b = 8'((10'(top.b) + 10'(pr.b)) >> 2);
			g = 8'((10'(top.g) + 10'(pr.g)) >> 2);
			r = 8'((10'(top.r) + 10'(pr.r)) >> 2);
			a = 8'((10'(top.a) + 10'(pr.a)) >> 2);
			x = x >> 1;
			y = y >> 1;
			lvl++;
		end
		expected_results[expected_results.size() - 1].run_last = 1;
		if (last_px) begin
			expected_results[expected_results.size() - 1].image_done = 1;
			restart_image();
		end else begin
			col_cnt++;
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt++;
				if (row_cnt >= h) row_cnt = 0;
			end
		end
		if (first > expected_results.size()) errors++;
	endtask

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Random gap: mostly none or short, now and then long.
	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: offer queued pixels, predict on each transfer.
	int unsigned in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.data <= '0;
			in_gap <= 0;
		end else begin
			if (pix.valid && pix.ready)
				predict_mips(pix.data);
			if (!pix.valid || pix.ready) begin
				if (in_gap != 0) begin
					pix.valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (pending_pixels.size() != 0) begin
					pix.valid <= 1'b1;
					pix.data <= pending_pixels.pop_front();
					in_gap <= rand_gap();
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result, stall at random, hold off for a long stretch on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (res.valid && res.ready) begin
				pix_out_t got, want;
				got = res.data;
				if (expected_results.size() == 0) begin
					$display("MISMATCH unexpected result at %0t", $realtime);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.mip_level !== want.mip_level)
						report_mismatch("mip_level", got.mip_level, want.mip_level);
					if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
					if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
					if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
					if (got.green !== want.green) report_mismatch("green", got.green, want.green);
					if (got.red !== want.red) report_mismatch("red", got.red, want.red);
					if (got.alpha !== want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
					if (got.alpha_seen !== want.alpha_seen)
						report_mismatch("alpha_seen", got.alpha_seen, want.alpha_seen);
					if (got.run_last !== want.run_last)
						report_mismatch("run_last", got.run_last, want.run_last);
					if (got.image_done !== want.image_done)
						report_mismatch("image_done", got.image_done, want.image_done);
				end
			end
			if (long_stall_req) begin
				res.ready <= 1'b0;
				out_stall <= 300;
			end else if (out_stall != 0) begin
				res.ready <= 1'b0;
				out_stall <= out_stall - 1;
			end else if ($urandom_range(0, 3) == 0) begin
				res.ready <= 1'b0;
				out_stall <= rand_gap();
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles in which no transfer happens on either side.
	always @(posedge clk) begin
		if (!arst_n || (pix.valid && pix.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT_CYCLES) begin
			$display("rgba_pack_and_mip_chain test failed");
			$finish;
		end
	end

	// Wait until every queued pixel is taken and every result has come, then
	// let the block settle before touching configuration.
	task automatic drain();
		while (pending_pixels.size() != 0 || pix.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_COMPONENTS) comp_cnt = val & 7;
		else if (idx == REG_WIDTH) img_w = val & 12'hFFF;
		else img_h = val & 12'hFFF;
		restart_image();
	endtask

	function automatic pix_in_t rand_pixel();
		pix_in_t p;
		p.sample_first = $urandom();
		p.sample_second = $urandom();
		p.sample_third = $urandom();
		p.sample_fourth = $urandom();
		// bias alpha toward the threshold so the flag both sets and stays clear
		if ($urandom_range(0, 2) == 0) p.sample_fourth = $urandom_range(240, 255);
		if ($urandom_range(0, 2) == 0) p.sample_second = $urandom_range(240, 255);
		return p;
	endfunction

	task automatic push_image(int unsigned npix);
		repeat (npix) pending_pixels.push_back(rand_pixel());
	endtask

	task automatic configure(int unsigned cc, int unsigned w, int unsigned h);
		write_reg(REG_COMPONENTS, cc);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	initial begin
		pix_in_t p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_COMPONENTS;
		cfg_data = '0;
		errors = 0;
		long_stall_req = 0;
		comp_cnt = 4;
		img_w = 1024;
		img_h = 1024;
		restart_image();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 4x4 RGBA with extreme samples, full three-level cascade
		configure(4, 4, 4);
		p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_00F8};
		pending_pixels.push_back(p);
		p = '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF};
		pending_pixels.push_back(p);
		p = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_00F7};
		pending_pixels.push_back(p);
		push_image(13);
		drain();

		// greyscale and grey+alpha, odd sizes that drop a column and a row
		configure(1, 3, 3);
		push_image(9);
		drain();
		configure(2, 5, 3);
		push_image(15);
		drain();
		// zero count means grey, seven means RGBA; zero size means 1x1
		configure(0, 0, 0);
		push_image(2);
		drain();
		configure(7, 2, 2);
		push_image(4);
		drain();

		// long output hold-off while input keeps coming
		configure(3, 8, 4);
		push_image(32);
		long_stall_req <= 1;
		@(posedge clk);
		long_stall_req <= 0;
		drain();

		// wide thin image: full-width counter extreme, one level
		configure(4, 4095, 1);
		push_image(6);
		drain();
		configure(3, 2048, 2);
		push_image(8);
		drain();

		// random images of small size
		repeat (2) begin
			int unsigned w, h;
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			configure($urandom_range(1, 4), w, h);
			push_image(w * h + $urandom_range(0, 3));
			drain();
		end

		drain();
		if (errors == 0)
			$display("rgba_pack_and_mip_chain test passed");
		else
			$display("rgba_pack_and_mip_chain test failed");
		$finish;
	end
endmodule
